FILE: hw/rtl/lfr_pkg.sv
// Shared types and constants for the LRU frame replacer.
package lfr_pkg;

    localparam int FRAME_W = 6;
    localparam int CNT_W   = 7;

    typedef enum logic [1:0] {
        OP_VICTIM = 2'd0,
        OP_PIN    = 2'd1,
        OP_UNPIN  = 2'd2
    } op_t;

endpackage

FILE: hw/rtl/lru_frame_replacer_top.sv
// LRU frame replacer: list of evictable frames held in a row of shifting cells.
// An accepted transaction passes the input register, then the result register.
// One operation per cycle unless out_stall; every cell compares and shifts in the same cycle.
// Cell 0 holds the oldest frame, so a victim reads a fixed position.
// Reset (rst_n low, asynchronous) empties the list and clears every listed flag.
// The cells hold no reset value; only positions below the list length are used.
module lru_frame_replacer_top
    import lfr_pkg::*;
#(
    parameter int NUM_FRAMES = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         op,
    input  logic [FRAME_W-1:0] frame,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               victim_found,
    output logic [FRAME_W-1:0] victim_frame,
    output logic [CNT_W-1:0]   listed_count
);

    localparam int LEN_W = $clog2(NUM_FRAMES + 1);
    localparam int LVLS  = ($clog2(NUM_FRAMES) < 1) ? 1 : $clog2(NUM_FRAMES);

    // input stage
    logic               valid1_reg;
    logic [1:0]         op1_reg;
    logic [FRAME_W-1:0] frame1_reg;

    // list state
    logic [FRAME_W-1:0]    cell_reg [NUM_FRAMES];
    logic [FRAME_W-1:0]    cell_next [NUM_FRAMES];
    logic [NUM_FRAMES-1:0] flags_reg;
    logic [NUM_FRAMES-1:0] flags_next;
    logic [LEN_W-1:0]      len_reg;
    logic [LEN_W-1:0]      len_next;

    // result stage
    logic               out_valid_reg;
    logic               found_reg;
    logic [FRAME_W-1:0] vframe_reg;
    logic [CNT_W-1:0]   count_reg;

    logic s2_load;
    logic adv;
    logic in_accept;

    logic [NUM_FRAMES-1:0] frame_hit;
    logic [NUM_FRAMES-1:0] vict_hit;
    logic [NUM_FRAMES-1:0] pos_valid;
    logic [NUM_FRAMES-1:0] match;
    logic [NUM_FRAMES-1:0] pfx [LVLS+1];
    logic [NUM_FRAMES-1:0] shift;
    logic                  in_range;
    logic                  listed;
    logic                  victim_do;
    logic                  pin_do;
    logic                  unpin_do;

    assign s2_load   = !out_valid_reg || !out_stall;
    assign adv       = valid1_reg && s2_load;
    assign in_stall  = valid1_reg && !s2_load;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        for (int f = 0; f < NUM_FRAMES; f++)
        begin
            frame_hit[f] = (f < (1 << FRAME_W)) && (frame1_reg == FRAME_W'(f));
            vict_hit[f]  = (f < (1 << FRAME_W)) && (cell_reg[0] == FRAME_W'(f));
            pos_valid[f] = LEN_W'(f) < len_reg;
            match[f]     = pos_valid[f] && (cell_reg[f] == frame1_reg);
        end
    end

    assign in_range = |frame_hit;
    assign listed   = |(frame_hit & flags_reg);

    assign victim_do = adv && (op1_reg == OP_VICTIM) && (len_reg != '0);
    assign pin_do    = adv && (op1_reg == OP_PIN) && listed;
    assign unpin_do  = adv && (op1_reg == OP_UNPIN) && in_range && !listed
                       && (len_reg < LEN_W'(NUM_FRAMES));

    // prefix OR: every position at or above the pinned frame moves down one
    always_comb
    begin
        pfx[0] = match;
        for (int l = 0; l < LVLS; l++)
        begin
            pfx[l+1] = pfx[l] | (pfx[l] << (1 << l));
        end
        shift = {NUM_FRAMES{victim_do}} | ({NUM_FRAMES{pin_do}} & pfx[LVLS]);
    end

    always_comb
    begin
        for (int i = 0; i < NUM_FRAMES; i++)
        begin
            if (shift[i])
            begin
                cell_next[i] = (i + 1 < NUM_FRAMES) ? cell_reg[(i + 1) % NUM_FRAMES]
                                                    : cell_reg[i];
            end
            else if (unpin_do && (LEN_W'(i) == len_reg))
            begin
                cell_next[i] = frame1_reg;
            end
            else
            begin
                cell_next[i] = cell_reg[i];
            end
        end
    end

    always_comb
    begin
        for (int f = 0; f < NUM_FRAMES; f++)
        begin
            flags_next[f] = flags_reg[f];
            if (unpin_do && frame_hit[f])
            begin
                flags_next[f] = 1'b1;
            end
            if ((pin_do && frame_hit[f]) || (victim_do && vict_hit[f]))
            begin
                flags_next[f] = 1'b0;
            end
        end
    end

    always_comb
    begin
        priority if (victim_do || pin_do)
        begin
            len_next = len_reg - LEN_W'(1);
        end
        else if (unpin_do)
        begin
            len_next = len_reg + LEN_W'(1);
        end
        else
        begin
            len_next = len_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            flags_reg     <= '0;
            len_reg       <= '0;
        end
        else
        begin
            if (in_accept)
            begin
                valid1_reg <= 1'b1;
            end
            else if (adv)
            begin
                valid1_reg <= 1'b0;
            end
            if (s2_load)
            begin
                out_valid_reg <= valid1_reg;
            end
            flags_reg <= flags_next;
            len_reg   <= len_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            op1_reg    <= op;
            frame1_reg <= frame;
        end
        if (adv)
        begin
            found_reg  <= victim_do;
            vframe_reg <= victim_do ? cell_reg[0] : '0;
            count_reg  <= CNT_W'(len_next);
            for (int i = 0; i < NUM_FRAMES; i++)
            begin
                cell_reg[i] <= cell_next[i];
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign victim_found = found_reg;
    assign victim_frame = vframe_reg;
    assign listed_count = count_reg;

    // one flag set for each listed frame
    a_flags_match_len: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(flags_reg) == int'(len_reg))
        else $error("listed flags disagree with list length");

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LEN_W'(NUM_FRAMES))
        else $error("list length beyond capacity");

    a_no_victim_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !found_reg |-> vframe_reg == '0)
        else $error("victim frame set without a victim");

    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> valid1_reg && out_valid_reg)
        else $error("input stalled with an empty pipeline");

    a_victim_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        victim_do |=> len_reg == $past(len_reg) - LEN_W'(1))
        else $error("victim did not shorten the list");

endmodule

FILE: tb/lru_replacer_checker.sv
// Checker for the LRU frame replacer: predicts every result and compares the outputs.
module lru_replacer_checker
    import lfr_pkg::*;
#(
    parameter int NUM_FRAMES = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [1:0]         op,
    input  logic [FRAME_W-1:0] frame,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic               victim_found,
    input  logic [FRAME_W-1:0] victim_frame,
    input  logic [CNT_W-1:0]   listed_count,
    output int                 fail_count,
    output int                 pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic               found;
        logic [FRAME_W-1:0] frame;
        logic [CNT_W-1:0]   count;
    } evict_result_t;

    // Newest frame at index 0, oldest at the back
    logic [FRAME_W-1:0] lru_order [$];
    bit                 frame_listed [NUM_FRAMES];
    evict_result_t      expected_results [$];
    int                 mismatches = 0;

    function automatic evict_result_t apply_op(logic [1:0] code, logic [FRAME_W-1:0] f);
        evict_result_t r;
        int            pos;
        r   = '0;
        pos = -1;
        case (code)
            OP_VICTIM:
            begin
                if (lru_order.size() > 0)
                begin
                    r.found = 1'b1;
                    r.frame = lru_order[lru_order.size() - 1];
                    lru_order.delete(lru_order.size() - 1);
                    frame_listed[r.frame] = 1'b0;
                end
            end
            OP_PIN:
            begin
                if (f < NUM_FRAMES && frame_listed[f])
                begin
                    for (int i = 0; i < lru_order.size(); i++)
                    begin
                        if (lru_order[i] == f && pos < 0)
                            pos = i;
                    end
                    if (pos >= 0)
                        lru_order.delete(pos);
                    frame_listed[f] = 1'b0;
                end
            end
            OP_UNPIN:
            begin
                // a listed frame keeps its place; a full list takes nothing
                if (f < NUM_FRAMES && !frame_listed[f] && lru_order.size() < NUM_FRAMES)
                begin
                    lru_order.insert(0, f);
                    frame_listed[f] = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        r.count = CNT_W'(lru_order.size());
        return r;
    endfunction

    always @(posedge clk)
    begin
        evict_result_t got;
        evict_result_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                got = {victim_found, victim_frame, listed_count};
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected result found %0d frame %0d count %0d",
                                 $realtime, got.found, got.frame, got.count);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.found !== want.found || got.frame !== want.frame ||
                        got.count !== want.count)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: expected found %0d frame %0d count %0d, got %0d %0d %0d",
                                     $realtime, want.found, want.frame, want.count,
                                     got.found, got.frame, got.count);
                    end
                end
            end
            if (in_valid && !in_stall)
                expected_results.push_back(apply_op(op, frame));
            fail_count <= mismatches;
            pending    <= expected_results.size();
        end
    end

endmodule

FILE: tb/tb_top.sv
// Testbench top for the LRU frame replacer: clock, reset, stimulus, back-pressure and verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lfr_pkg::*;

    localparam int         NUM_FRAMES   = 64;
    localparam int         TOTAL_ITEMS  = 1700;
    localparam int         IDLE_LIMIT   = 2000;
    localparam int         DRAIN_CYCLES = 10;
    localparam int         HOLD_START   = 400;
    localparam int         HOLD_LEN     = 150;
    localparam logic [1:0] OP_RESERVED  = 2'd3;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    logic [1:0]         op        = OP_VICTIM;
    logic [FRAME_W-1:0] frame     = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic               victim_found;
    logic [FRAME_W-1:0] victim_frame;
    logic [CNT_W-1:0]   listed_count;

    int fail_count;
    int pending;
    int items_sent  = 0;
    int idle_cycles = 0;

    always #5 clk = ~clk;

    lru_frame_replacer_top #(.NUM_FRAMES(NUM_FRAMES)) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .op           (op),
        .frame        (frame),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .victim_found (victim_found),
        .victim_frame (victim_frame),
        .listed_count (listed_count)
    );

    lru_replacer_checker #(.NUM_FRAMES(NUM_FRAMES)) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .op           (op),
        .frame        (frame),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .victim_found (victim_found),
        .victim_frame (victim_frame),
        .listed_count (listed_count),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    // Returns once the transaction has been taken
    task automatic send_op(input logic [1:0] code, input logic [FRAME_W-1:0] f);
        while (!(items_sent >= 600 && items_sent < 900) && $urandom_range(99) < 15)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        op       <= code;
        frame    <= f;
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
    endtask

    function automatic logic [1:0] pick_op(int w_victim, int w_pin, int w_unpin);
        int r;
        r = $urandom_range(99);
        if (r < w_victim)
            return OP_VICTIM;
        if (r < w_victim + w_pin)
            return OP_PIN;
        if (r < w_victim + w_pin + w_unpin)
            return OP_UNPIN;
        return OP_RESERVED;
    endfunction

    initial
    begin
        logic [FRAME_W-1:0] perm [NUM_FRAMES];
        logic [FRAME_W-1:0] tmp;
        int                 j;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty list, absent pins, duplicate unpins, unused code, pins at each end
        send_op(OP_VICTIM,   6'd0);
        send_op(OP_PIN,      6'd5);
        send_op(OP_RESERVED, 6'd0);
        send_op(OP_UNPIN,    6'd0);
        send_op(OP_UNPIN,    6'd63);
        send_op(OP_UNPIN,    6'd0);
        send_op(OP_UNPIN,    6'd21);
        send_op(OP_PIN,      6'd63);
        send_op(OP_PIN,      6'd63);
        send_op(OP_RESERVED, 6'd63);
        send_op(OP_VICTIM,   6'd63);
        send_op(OP_UNPIN,    6'd42);
        send_op(OP_VICTIM,   6'd0);
        send_op(OP_VICTIM,   6'd0);
        send_op(OP_VICTIM,   6'd0);
        send_op(OP_UNPIN,    6'd63);
        send_op(OP_PIN,      6'd63);
        send_op(OP_UNPIN,    6'd1);
        send_op(OP_UNPIN,    6'd2);
        send_op(OP_UNPIN,    6'd1);
        send_op(OP_PIN,      6'd2);
        send_op(OP_VICTIM,   6'd0);

        while (items_sent < TOTAL_ITEMS)
        begin
            case ($urandom_range(3))
                0:
                begin
                    // list every frame in shuffled order, then knock on a full list
                    for (int i = 0; i < NUM_FRAMES; i++)
                        perm[i] = FRAME_W'(i);
                    for (int i = NUM_FRAMES - 1; i > 0; i--)
                    begin
                        j       = $urandom_range(i);
                        tmp     = perm[i];
                        perm[i] = perm[j];
                        perm[j] = tmp;
                    end
                    for (int i = 0; i < NUM_FRAMES; i++)
                    begin
                        send_op(OP_UNPIN, perm[i]);
                        if ($urandom_range(99) < 10)
                            send_op($urandom_range(1) ? OP_UNPIN : OP_RESERVED,
                                    FRAME_W'($urandom_range(NUM_FRAMES - 1)));
                    end
                    repeat (4) send_op(OP_UNPIN, FRAME_W'($urandom_range(NUM_FRAMES - 1)));
                end
                1:
                    repeat (80) send_op(pick_op(30, 30, 35),
                                        FRAME_W'($urandom_range(NUM_FRAMES - 1)));
                2:
                    repeat (70) send_op(pick_op(85, 10, 5),
                                        FRAME_W'($urandom_range(NUM_FRAMES - 1)));
                default:
                    repeat (80) send_op(pick_op(20, 20, 58),
                                        FRAME_W'($urandom_range(NUM_FRAMES - 1)));
            endcase
        end
        in_valid <= 1'b0;

        do
            @(posedge clk);
        while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Receiver: random stalls, one long hold-off so the block backs up, then a clean stretch
    initial
    begin
        int cyc;
        cyc = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            cyc++;
            if (cyc >= HOLD_START && cyc < HOLD_START + HOLD_LEN)
                out_stall <= 1'b1;
            else if (cyc >= 900 && cyc < 1400)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(99) < 15);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule

FILE: lru_frame_replacer_top.f
hw/rtl/lfr_pkg.sv
hw/rtl/lru_frame_replacer_top.sv
tb/lru_replacer_checker.sv
tb/tb_top.sv
